>>> hdl/collinear_segment_merge_defines.svh
// Assertion macros shared by the collinear segment merge RTL.
`ifndef COLLINEAR_SEGMENT_MERGE_DEFINES_SVH
`define COLLINEAR_SEGMENT_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CSM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CSM_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/csm_pkg.sv
// Types, widths and point helpers for the collinear segment merge.
package csm_pkg;

    localparam int CoordW = 32;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int LayerW = 2;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
    } pt_t;

    typedef struct packed {
        pt_t               a_s;
        pt_t               a_e;
        pt_t               b_s;
        pt_t               b_e;
        logic [LayerW-1:0] a_layer;
        logic [LayerW-1:0] b_layer;
        logic              sel;
    } in_beat_t;

    typedef struct packed {
        pt_t                     ls;
        pt_t                     fe;
        logic                    sel;
        logic                    reach_ok;
        logic                    ident;
        logic                    hv_case;
        logic                    hv_ok;
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic signed [DiffW-1:0] d1x;
        logic signed [DiffW-1:0] d1y;
        logic signed [DiffW-1:0] d2x;
        logic signed [DiffW-1:0] d2y;
    } geo_t;

    typedef struct packed {
        pt_t                     ls;
        pt_t                     fe;
        logic                    sel;
        logic                    reach_ok;
        logic                    ident;
        logic                    hv_case;
        logic                    hv_ok;
        logic signed [ProdW-1:0] p1;
        logic signed [ProdW-1:0] p2;
        logic signed [ProdW-1:0] p3;
        logic signed [ProdW-1:0] p4;
    } prod_t;

    // lexicographic (x, y) compare
    function automatic logic pt_less(pt_t p, pt_t q);
        if ($signed(p.x) == $signed(q.x)) begin
            return $signed(p.y) < $signed(q.y);
        end
        return $signed(p.x) < $signed(q.x);
    endfunction

    // exact difference, one bit wider than the coordinates
    function automatic logic signed [DiffW-1:0] diff(logic signed [CoordW-1:0] a,
                                                     logic signed [CoordW-1:0] b);
        return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    endfunction

endpackage

>>> hdl/collinear_segment_merge.sv
// Collinear segment merge: four-stage pipeline deciding if two segments fuse into one.
//
// Input channel (s_valid/s_ready): one beat carries two segments A and B, each
// with start and end points, a layer code and a selected flag.
// Result channel (m_valid/m_ready): one beat per input beat, in order. m_merged
// says whether the pair collapses into a single segment running from the
// leftmost start to the farthest end; when it is low every other field is 0.
// A beat accepted into the input register passes through the difference and product
// registers to the result register. Throughput: one beat per cycle while m_ready stays high.
// Stages: input register, endpoint ordering and differences, four 33x33 exact
// cross products, final compare into the result register. The multiplier stage
// sets the clock.
// Reset (aresetn low, synchronous) empties the pipeline; no state survives
// between beats. When m_ready is low the pipeline fills up behind the held
// result and s_ready drops only once every stage holds a beat.
`include "collinear_segment_merge_defines.svh"

module collinear_segment_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [csm_pkg::CoordW-1:0]    s_a_start_x,
    input  logic signed [csm_pkg::CoordW-1:0]    s_a_start_y,
    input  logic signed [csm_pkg::CoordW-1:0]    s_a_end_x,
    input  logic signed [csm_pkg::CoordW-1:0]    s_a_end_y,
    input  logic        [csm_pkg::LayerW-1:0]    s_a_layer,
    input  logic                                 s_a_selected,
    input  logic signed [csm_pkg::CoordW-1:0]    s_b_start_x,
    input  logic signed [csm_pkg::CoordW-1:0]    s_b_start_y,
    input  logic signed [csm_pkg::CoordW-1:0]    s_b_end_x,
    input  logic signed [csm_pkg::CoordW-1:0]    s_b_end_y,
    input  logic        [csm_pkg::LayerW-1:0]    s_b_layer,
    input  logic                                 s_b_selected,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_merged,
    output logic signed [csm_pkg::CoordW-1:0]    m_out_start_x,
    output logic signed [csm_pkg::CoordW-1:0]    m_out_start_y,
    output logic signed [csm_pkg::CoordW-1:0]    m_out_end_x,
    output logic signed [csm_pkg::CoordW-1:0]    m_out_end_y,
    output logic                                 m_out_selected
);
    import csm_pkg::*;

    in_beat_t in_reg;
    in_beat_t in_next;
    logic     in_vld_reg;
    geo_t     geo_reg;
    geo_t     geo_next;
    logic     geo_vld_reg;
    prod_t    prod_reg;
    prod_t    prod_next;
    logic     prod_vld_reg;
    logic     out_vld_reg;
    logic     merged_reg;
    logic     merged_next;
    pt_t      start_reg;
    pt_t      start_next;
    pt_t      end_reg;
    pt_t      end_next;
    logic     sel_reg;
    logic     sel_next;

    logic adv_geo;
    logic adv_prod;
    logic adv_out;

    pt_t  as, ae, bs, be, ls, le, os, oe;
    logic horiz;
    logic vert;
    logic ok;

    // stall chain: a stage moves when its successor is empty or moving
    assign adv_out  = !out_vld_reg || m_ready;
    assign adv_prod = !prod_vld_reg || adv_out;
    assign adv_geo  = !geo_vld_reg || adv_prod;
    assign s_ready  = !in_vld_reg || adv_geo;

    always_comb begin
        in_next.a_s     = '{x: s_a_start_x, y: s_a_start_y};
        in_next.a_e     = '{x: s_a_end_x,   y: s_a_end_y};
        in_next.b_s     = '{x: s_b_start_x, y: s_b_start_y};
        in_next.b_e     = '{x: s_b_end_x,   y: s_b_end_y};
        in_next.a_layer = s_a_layer;
        in_next.b_layer = s_b_layer;
        in_next.sel     = s_a_selected | s_b_selected;
    end

    // stage 2: order endpoints, pick leftmost, flags and differences
    always_comb begin
        as = pt_less(in_reg.a_e, in_reg.a_s) ? in_reg.a_e : in_reg.a_s;
        ae = pt_less(in_reg.a_e, in_reg.a_s) ? in_reg.a_s : in_reg.a_e;
        bs = pt_less(in_reg.b_e, in_reg.b_s) ? in_reg.b_e : in_reg.b_s;
        be = pt_less(in_reg.b_e, in_reg.b_s) ? in_reg.b_s : in_reg.b_e;
        if (pt_less(as, bs)) begin
            ls = as; le = ae; os = bs; oe = be;
        end else begin
            ls = bs; le = be; os = as; oe = ae;
        end
        horiz = (ls.y == le.y) && (os.y == oe.y);
        vert  = (ls.x == le.x) && (os.x == oe.x);

        geo_next.ls       = ls;
        geo_next.fe       = pt_less(oe, le) ? le : oe;
        geo_next.sel      = in_reg.sel;
        geo_next.reach_ok = (in_reg.a_layer == in_reg.b_layer) && !pt_less(le, os);
        geo_next.ident    = (ls == os) && (le == oe);
        geo_next.hv_case  = horiz || vert;
        geo_next.hv_ok    = horiz ? (ls.y == os.y) : (ls.x == os.x);
        geo_next.dx       = diff(le.x, ls.x);
        geo_next.dy       = diff(le.y, ls.y);
        geo_next.d1x      = diff(os.x, ls.x);
        geo_next.d1y      = diff(os.y, ls.y);
        geo_next.d2x      = diff(oe.x, ls.x);
        geo_next.d2y      = diff(oe.y, ls.y);
    end

    // stage 3: exact cross products
    always_comb begin
        prod_next.ls       = geo_reg.ls;
        prod_next.fe       = geo_reg.fe;
        prod_next.sel      = geo_reg.sel;
        prod_next.reach_ok = geo_reg.reach_ok;
        prod_next.ident    = geo_reg.ident;
        prod_next.hv_case  = geo_reg.hv_case;
        prod_next.hv_ok    = geo_reg.hv_ok;
        prod_next.p1       = ProdW'(geo_reg.d1y * geo_reg.dx);
        prod_next.p2       = ProdW'(geo_reg.d1x * geo_reg.dy);
        prod_next.p3       = ProdW'(geo_reg.d2y * geo_reg.dx);
        prod_next.p4       = ProdW'(geo_reg.d2x * geo_reg.dy);
    end

    // stage 4: final decision
    always_comb begin
        ok = prod_reg.reach_ok &&
             (prod_reg.ident ||
              (prod_reg.hv_case ? prod_reg.hv_ok
                                : ((prod_reg.p1 == prod_reg.p2) &&
                                   (prod_reg.p3 == prod_reg.p4))));
        merged_next = ok;
        start_next  = ok ? prod_reg.ls : '0;
        end_next    = ok ? prod_reg.fe : '0;
        sel_next    = ok ? prod_reg.sel : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            geo_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (adv_geo) begin
                geo_vld_reg <= in_vld_reg;
            end
            if (adv_prod) begin
                prod_vld_reg <= geo_vld_reg;
            end
            if (adv_out) begin
                out_vld_reg <= prod_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= in_next;
        end
        if (in_vld_reg && adv_geo) begin
            geo_reg <= geo_next;
        end
        if (geo_vld_reg && adv_prod) begin
            prod_reg <= prod_next;
        end
        if (prod_vld_reg && adv_out) begin
            merged_reg <= merged_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            sel_reg    <= sel_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_merged       = merged_reg;
    assign m_out_start_x  = start_reg.x;
    assign m_out_start_y  = start_reg.y;
    assign m_out_end_x    = end_reg.x;
    assign m_out_end_y    = end_reg.y;
    assign m_out_selected = sel_reg;

    `CSM_ASSERT_IMP(a_no_merge_zero, aclk, aresetn, m_valid && !m_merged, (m_out_start_x == 0) && (m_out_start_y == 0) && (m_out_end_x == 0) && (m_out_end_y == 0) && !m_out_selected, "unmerged beat carries nonzero fields")
    `CSM_ASSERT_IMP(a_merge_ordered, aclk, aresetn, m_valid && m_merged, !((m_out_end_x < m_out_start_x) || ((m_out_end_x == m_out_start_x) && (m_out_end_y < m_out_start_y))), "merged end lies before merged start")
    `CSM_ASSERT_IMP(a_stall_only_full, aclk, aresetn, !s_ready, in_vld_reg && geo_vld_reg && prod_vld_reg && out_vld_reg && !m_ready, "input stalled with a bubble in the pipeline")
    `CSM_ASSERT_NXT(a_prod_to_out, aclk, aresetn, prod_vld_reg && adv_out, out_vld_reg, "product stage beat lost on its way to the output")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for collinear_segment_merge: directed and random segment pairs.
module testbench;

    localparam int     CMIN  = 32'h8000_0000;
    localparam int     CMAX  = 32'h7fff_ffff;
    localparam longint CLO   = -64'sd2147483648;
    localparam longint CHI   = 64'sd2147483647;
    localparam int     NRAND = 800;
    localparam int     LIMIT = 2000;

    typedef struct packed {
        csm_pkg::pt_t                 a_s;
        csm_pkg::pt_t                 a_e;
        csm_pkg::pt_t                 b_s;
        csm_pkg::pt_t                 b_e;
        logic [csm_pkg::LayerW-1:0]   a_layer;
        logic [csm_pkg::LayerW-1:0]   b_layer;
        logic                         a_sel;
        logic                         b_sel;
    } seg_pair_t;

    typedef struct packed {
        logic         merged;
        csm_pkg::pt_t head;
        csm_pkg::pt_t tail;
        logic         sel;
    } merge_res_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       m_ready = 1'b0;
    seg_pair_t  cur     = '0;
    wire        s_ready;
    wire        m_valid;
    wire        m_merged;
    wire        m_out_selected;
    wire signed [csm_pkg::CoordW-1:0] m_out_start_x;
    wire signed [csm_pkg::CoordW-1:0] m_out_start_y;
    wire signed [csm_pkg::CoordW-1:0] m_out_end_x;
    wire signed [csm_pkg::CoordW-1:0] m_out_end_y;

    seg_pair_t  pair_q[$];
    merge_res_t merge_q[$];
    int         errors    = 0;
    int         cyc       = 0;
    int         stall     = 0;
    int         hold_left = 0;
    wire        calm = (cyc >= 500) && (cyc < 800);

    collinear_segment_merge u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_a_start_x    (cur.a_s.x),
        .s_a_start_y    (cur.a_s.y),
        .s_a_end_x      (cur.a_e.x),
        .s_a_end_y      (cur.a_e.y),
        .s_a_layer      (cur.a_layer),
        .s_a_selected   (cur.a_sel),
        .s_b_start_x    (cur.b_s.x),
        .s_b_start_y    (cur.b_s.y),
        .s_b_end_x      (cur.b_e.x),
        .s_b_end_y      (cur.b_e.y),
        .s_b_layer      (cur.b_layer),
        .s_b_selected   (cur.b_sel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_merged       (m_merged),
        .m_out_start_x  (m_out_start_x),
        .m_out_start_y  (m_out_start_y),
        .m_out_end_x    (m_out_end_x),
        .m_out_end_y    (m_out_end_y),
        .m_out_selected (m_out_selected)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // lexicographic (x, y) order
    function automatic logic precedes(csm_pkg::pt_t p, csm_pkg::pt_t q);
        if (p.x == q.x) begin
            return $signed(p.y) < $signed(q.y);
        end
        return $signed(p.x) < $signed(q.x);
    endfunction

    // exact test that q lies on the line through base with direction (dx, dy)
    function automatic logic on_line(csm_pkg::pt_t base, logic signed [67:0] dx,
                                     logic signed [67:0] dy, csm_pkg::pt_t q);
        logic signed [67:0] qx, qy;
        qx = $signed(q.x);
        qy = $signed(q.y);
        qx = qx - $signed(base.x);
        qy = qy - $signed(base.y);
        return qy * dx == qx * dy;
    endfunction

    function automatic merge_res_t merge_segments(seg_pair_t p);
        csm_pkg::pt_t a0, a1, b0, b1, ls, le, os, oe, fe, t;
        logic signed [67:0] dx, dy;
        logic ok;
        merge_res_t r;
        a0 = p.a_s; a1 = p.a_e; b0 = p.b_s; b1 = p.b_e;
        if (precedes(a1, a0)) begin
            t = a0; a0 = a1; a1 = t;
        end
        if (precedes(b1, b0)) begin
            t = b0; b0 = b1; b1 = t;
        end
        if (precedes(a0, b0)) begin
            ls = a0; le = a1; os = b0; oe = b1;
        end else begin
            ls = b0; le = b1; os = a0; oe = a1;
        end
        fe = precedes(oe, le) ? le : oe;
        ok = 1'b0;
        if (p.a_layer == p.b_layer && !precedes(le, os)) begin
            if (ls == os && le == oe) begin
                ok = 1'b1;
            end else if (ls.y == le.y && os.y == oe.y) begin
                ok = (ls.y == os.y);
            end else if (ls.x == le.x && os.x == oe.x) begin
                ok = (ls.x == os.x);
            end else begin
                dx = $signed(le.x);
                dy = $signed(le.y);
                dx = dx - $signed(ls.x);
                dy = dy - $signed(ls.y);
                ok = on_line(ls, dx, dy, os) && on_line(ls, dx, dy, oe);
            end
        end
        r = '0;
        if (ok) begin
            r.merged = 1'b1;
            r.head   = ls;
            r.tail   = fe;
            r.sel    = p.a_sel | p.b_sel;
        end
        return r;
    endfunction

    function automatic seg_pair_t pair(int ax0, int ay0, int ax1, int ay1, int al, int asl,
                                       int bx0, int by0, int bx1, int by1, int bl, int bsl);
        seg_pair_t p;
        p.a_s.x = ax0; p.a_s.y = ay0; p.a_e.x = ax1; p.a_e.y = ay1;
        p.b_s.x = bx0; p.b_s.y = by0; p.b_e.x = bx1; p.b_e.y = by1;
        p.a_layer = al[1:0]; p.a_sel = asl[0];
        p.b_layer = bl[1:0]; p.b_sel = bsl[0];
        return p;
    endfunction

    function automatic longint pick(longint lo, longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return lo + longint'(r % longint'(hi - lo + 1));
    endfunction

    function automatic csm_pkg::pt_t on_ray(longint px, longint py, longint dx, longint dy,
                                            int t);
        csm_pkg::pt_t q;
        longint x, y;
        x = px + t * dx;
        y = py + t * dy;
        q.x = x[31:0];
        q.y = y[31:0];
        return q;
    endfunction

    function automatic seg_pair_t collinear_pair();
        seg_pair_t p;
        csm_pkg::pt_t t;
        longint span, dx, dy, px, py;
        int kind;
        span = longint'(1) << $urandom_range(27);
        kind = $urandom_range(3);
        dx = (kind == 1) ? 0 : pick(-span, span);
        dy = (kind == 0) ? 0 : pick(-span, span);
        px = pick(CLO - ((dx < 0) ? 15 * dx : 0), CHI - ((dx > 0) ? 15 * dx : 0));
        py = pick(CLO - ((dy < 0) ? 15 * dy : 0), CHI - ((dy > 0) ? 15 * dy : 0));
        p.a_s = on_ray(px, py, dx, dy, $urandom_range(15));
        p.a_e = on_ray(px, py, dx, dy, $urandom_range(15));
        p.b_s = on_ray(px, py, dx, dy, $urandom_range(15));
        p.b_e = on_ray(px, py, dx, dy, $urandom_range(15));
        if ($urandom_range(11) == 0) begin
            p.b_s = p.a_s;
            p.b_e = p.a_e;
            if ($urandom_range(1)) begin
                t = p.b_s; p.b_s = p.b_e; p.b_e = t;
            end
        end
        // near miss: one coordinate off by one
        if ($urandom_range(6) == 0) begin
            case ($urandom_range(3))
                0: p.b_s.x = p.b_s.x + 1;
                1: p.b_e.y = p.b_e.y - 1;
                2: p.a_e.x = p.a_e.x - 1;
                default: p.a_s.y = p.a_s.y + 1;
            endcase
        end
        p.a_layer = csm_pkg::LayerW'($urandom_range(3));
        p.b_layer = ($urandom_range(7) == 0) ? csm_pkg::LayerW'($urandom_range(3)) : p.a_layer;
        p.a_sel = 1'($urandom_range(1));
        p.b_sel = 1'($urandom_range(1));
        return p;
    endfunction

    function automatic seg_pair_t noise_pair();
        return pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic queue_pair(seg_pair_t p);
        pair_q.insert(pair_q.size(), p);
    endtask

    initial begin
        queue_pair(pair(0, 0, 0, 0, 3, 0, 0, 0, 0, 0, 3, 0));
        queue_pair(pair(1, 2, 10, 20, 1, 1, 10, 20, 1, 2, 1, 0));
        queue_pair(pair(1, 2, 10, 20, 1, 1, 10, 20, 1, 2, 2, 1));
        queue_pair(pair(0, 5, 10, 5, 0, 0, 4, 5, 20, 5, 0, 1));
        queue_pair(pair(0, 5, 10, 5, 0, 1, 4, 6, 20, 6, 0, 1));
        queue_pair(pair(7, -3, 7, 9, 2, 0, 7, 20, 7, 0, 2, 0));
        queue_pair(pair(7, -3, 7, 9, 2, 1, 8, 0, 8, 20, 2, 0));
        queue_pair(pair(0, 0, 6, 3, 1, 0, 4, 2, 10, 5, 1, 1));
        queue_pair(pair(0, 0, 6, 3, 1, 0, 4, 2, 10, 6, 1, 1));
        queue_pair(pair(0, 0, 2, 1, 0, 1, 4, 2, 10, 5, 0, 1));
        queue_pair(pair(0, 0, 4, 2, 3, 1, 4, 2, 10, 5, 3, 0));
        queue_pair(pair(0, 0, 4, 2, 0, 0, 0, 0, 8, 4, 0, 1));
        queue_pair(pair(10, 5, 0, 0, 1, 1, 4, 2, 2, 1, 1, 1));
        queue_pair(pair(5, 5, 9, 12, 2, 0, 5, 5, 5, 5, 2, 1));
        queue_pair(pair(0, 0, 6, 3, 0, 0, 2, 1, 2, 1, 0, 0));
        queue_pair(pair(0, 0, 6, 3, 0, 0, 2, 2, 2, 2, 0, 1));
        queue_pair(pair(CMIN, CMIN, CMAX, CMIN, 3, 1, 0, CMIN, CMAX, CMIN, 3, 1));
        queue_pair(pair(CMIN, CMIN, CMAX, CMAX, 1, 0, 0, 0, CMAX, CMAX, 1, 1));
        queue_pair(pair(CMIN, CMAX, CMAX, CMIN, 2, 1, CMIN, CMAX, -1, -1, 2, 0));
        queue_pair(pair(CMAX, CMIN, CMAX, CMAX, 0, 1, CMAX, 5, CMAX, CMIN, 0, 0));
        queue_pair(pair(0, 0, 10, 0, 3, 0, 5, -5, 5, 5, 3, 1));
        queue_pair(pair(-1, -1, -1, -1, 3, 1, -1, -1, -1, -1, 3, 1));
        for (int i = 0; i < NRAND; i++) begin
            queue_pair(($urandom_range(99) < 85) ? collinear_pair() : noise_pair());
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pair_q.size() != 0 || s_valid || merge_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (errors == 0 && merge_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // sender
    always @(posedge aclk) begin
        logic gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                merge_q.insert(merge_q.size(), merge_segments(cur));
            end
            if (!s_valid || s_ready) begin
                gap = !calm && ($urandom_range(99) < 27);
                if (pair_q.size() != 0 && !gap) begin
                    cur     <= pair_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back the pipeline up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cyc == 200) begin
                hold_left = 64;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 27);
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        merge_res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.merged = m_merged;
            got.head.x = m_out_start_x;
            got.head.y = m_out_start_y;
            got.tail.x = m_out_end_x;
            got.tail.y = m_out_end_y;
            got.sel    = m_out_selected;
            if (merge_q.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10) begin
                    $display("unexpected result beat: merged=%0d", got.merged);
                end
            end else begin
                want = merge_q.pop_front();
                if (got !== want) begin
                    errors = errors + 1;
                    if (errors <= 10) begin
                        $display("mismatch: exp merged=%0d start=(%0d,%0d) end=(%0d,%0d) sel=%0d",
                                 want.merged, $signed(want.head.x), $signed(want.head.y),
                                 $signed(want.tail.x), $signed(want.tail.y), want.sel);
                        $display("          got merged=%0d start=(%0d,%0d) end=(%0d,%0d) sel=%0d",
                                 got.merged, $signed(got.head.x), $signed(got.head.y),
                                 $signed(got.tail.x), $signed(got.tail.y), got.sel);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any beat on either channel
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall <= 0;
        end else if (stall == LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

endmodule
